// ===== design/delayed_task_queue_top_macros.svh =====
// Assertion macros used by the top design file.
`ifndef DELAYED_TASK_QUEUE_TOP_MACROS_SVH
`define DELAYED_TASK_QUEUE_TOP_MACROS_SVH
// Assert an implication on every clock, reset masked.
`define DTQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Assert an implication on the next clock.
`define DTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== design/dtq_pkg.sv =====
// ----------------------------------------------------------------------------
// dtq_pkg
// Types and constants of the delayed task queue.
// ----------------------------------------------------------------------------
package dtq_pkg;
   localparam int READY_DEPTH = 32;
   localparam int HEAP_DEPTH  = 16;
   localparam int TIME_BITS   = 32;
   localparam int TASK_BITS   = 16;
   localparam int IVAL_BITS   = 24;
   localparam int ORDER_BITS  = 16;
   localparam int MAX_RESULTS = 32;
   localparam int RA_BITS     = $clog2(READY_DEPTH);
   localparam int HA_BITS     = $clog2(HEAP_DEPTH);
   localparam int ENTRY_BITS  = TASK_BITS + IVAL_BITS;
   localparam int NODE_BITS   = TIME_BITS + ORDER_BITS + ENTRY_BITS;

   localparam logic [2:0] CMD_POST     = 3'd0;
   localparam logic [2:0] CMD_DELAYED  = 3'd1;
   localparam logic [2:0] CMD_PERIODIC = 3'd2;
   localparam logic [2:0] CMD_POLL     = 3'd3;
   localparam logic [2:0] CMD_TICK     = 3'd4;
   localparam logic [2:0] CMD_SHUTDOWN = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DROPPED = 2'd1;
   localparam logic [1:0] ST_IGNORED = 2'd2;

   typedef struct packed {
      logic [2:0]  command;
      logic [15:0] task_id;
      logic [23:0] delay_ticks;
      logic [5:0]  max_count;
      logic        unlimited;
   } req_type;

   typedef struct packed {
      logic [15:0] out_task;
      logic        task_valid;
      logic        periodic;
      logic        last;
      logic [5:0]  executed_count;
      logic [1:0]  status;
      logic        queues_empty;
   } rsp_type;

   // Heap node: due time, insertion order, entry (task above interval).
   typedef struct packed {
      logic [TIME_BITS-1:0]  due;
      logic [ORDER_BITS-1:0] order;
      logic [ENTRY_BITS-1:0] entry;
   } node_type;

   // Strict ordering of heap nodes.
   function automatic logic node_less(node_type a, node_type b);
      logic r;
      if (a.due != b.due) r = a.due < b.due;
      else r = a.order < b.order;
      return r;
   endfunction

   // Due time with saturation.
   function automatic logic [TIME_BITS-1:0] due_after(logic [TIME_BITS-1:0] now,
                                                     logic [IVAL_BITS-1:0] dly);
      logic [TIME_BITS:0] s;
      s = {1'b0, now} + (TIME_BITS+1)'(dly);
      return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
   endfunction
endpackage

// ===== design/dtq_ram.sv =====
// ----------------------------------------------------------------------------
// dtq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module dtq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_ff;
endmodule

// ===== design/delayed_task_queue_top.sv =====
// ----------------------------------------------------------------------------
// delayed_task_queue_top
// Ready FIFO plus delayed min-heap, both held in synchronous RAM.
// ----------------------------------------------------------------------------
// Usage: post, schedule, tick and shutdown each take one request beat and give
// one response beat. A heap insert sifts up one level at a time (read parent,
// compare and write back). A poll first moves each due heap root into the
// FIFO; every removal sifts down one level at a time (read left child, read
// right child, compare and write back) through the single heap read port. It
// then hands out tasks one by one through the FIFO RAM read port, waiting
// while a shown beat is held, plus a heap insert for each periodic task. One
// request is in flight at a time; the response register frees the input side
// once a beat is shown. Heap nodes and FIFO entries are not cleared on reset
// or shutdown: only the fill counts and the FIFO head are.
module delayed_task_queue_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dtq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dtq_pkg::rsp_type  rsp_data
);
`include "delayed_task_queue_top_macros.svh"

   // Sequencer states.
   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_DECODE  = 5'd1;
   localparam logic [4:0] S_HI_UP   = 5'd2;  // read parent for sift-up
   localparam logic [4:0] S_HI_CMP  = 5'd3;  // compare with parent
   localparam logic [4:0] S_MV_RD   = 5'd4;  // read root for due check
   localparam logic [4:0] S_MV_CHK  = 5'd5;
   localparam logic [4:0] S_PL_RD   = 5'd6;  // read last node
   localparam logic [4:0] S_PL_LAST = 5'd7;
   localparam logic [4:0] S_SD_L    = 5'd8;  // read left child
   localparam logic [4:0] S_SD_R    = 5'd9;  // read right child
   localparam logic [4:0] S_SD_CMP  = 5'd10;
   localparam logic [4:0] S_EM_RD   = 5'd11; // read FIFO head
   localparam logic [4:0] S_EM_GOT  = 5'd12;
   localparam logic [4:0] S_EM_OUT  = 5'd13; // result ready to show
   localparam logic [4:0] S_RESP    = 5'd14;
   localparam logic [4:0] S_WAIT    = 5'd15;

   localparam int RA = dtq_pkg::RA_BITS;
   localparam int HA = dtq_pkg::HA_BITS;

   logic [4:0] state_ff, state_in;
   logic [4:0] ret_ff, ret_in;           // state after a heap insert
   dtq_pkg::req_type req_ff, req_in;
   dtq_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [dtq_pkg::TIME_BITS-1:0]  time_ff, time_in;
   logic                           stopped_ff, stopped_in;
   logic [RA-1:0]                  head_ff, head_in;
   logic [RA:0]                    rfill_ff, rfill_in;
   logic [HA:0]                    hfill_ff, hfill_in;
   logic [dtq_pkg::ORDER_BITS-1:0] ictr_ff, ictr_in;

   // Working registers.
   dtq_pkg::node_type cur_ff, cur_in;    // node being sifted
   dtq_pkg::node_type lch_ff, lch_in;    // left child
   logic [HA-1:0]     idx_ff, idx_in;
   logic [5:0]        cnt_ff, cnt_in;    // tasks handed out
   logic [5:0]        lim_ff, lim_in;
   logic [dtq_pkg::ENTRY_BITS-1:0] ent_ff, ent_in;
   logic [1:0]        est_ff, est_in;

   // RAM ports.
   logic              h_we, r_we;
   logic [HA-1:0]     h_wa, h_ra;
   logic [RA-1:0]     r_wa, r_ra;
   dtq_pkg::node_type h_wd, h_rd;
   logic [dtq_pkg::ENTRY_BITS-1:0] r_wd, r_rd;

   dtq_ram #(.WIDTH(dtq_pkg::NODE_BITS), .DEPTH(dtq_pkg::HEAP_DEPTH)) u_heap (
      .clock(clock), .wr_en(h_we), .wr_addr(h_wa), .wr_data(h_wd),
      .rd_addr(h_ra), .rd_data(h_rd));

   dtq_ram #(.WIDTH(dtq_pkg::ENTRY_BITS), .DEPTH(dtq_pkg::READY_DEPTH)) u_fifo (
      .clock(clock), .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd),
      .rd_addr(r_ra), .rd_data(r_rd));

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic [HA:0] lidx, ridx, pidx;
   logic [RA:0] tail_sum;
   assign lidx = {idx_ff, 1'b1};
   assign ridx = {idx_ff, 1'b0} + (HA+1)'(2);
   assign pidx = ({1'b0, idx_ff} - (HA+1)'(1)) >> 1;
   assign tail_sum = {1'b0, head_ff} + rfill_ff;

   always_comb begin
      logic [dtq_pkg::TASK_BITS-1:0] t;
      logic [dtq_pkg::IVAL_BITS-1:0] iv;
      logic fin;
      state_in = state_ff; ret_in = ret_ff; req_in = req_ff;
      rsp_in = rsp_ff; rsp_valid_in = rsp_valid_ff;
      time_in = time_ff; stopped_in = stopped_ff; head_in = head_ff;
      rfill_in = rfill_ff; hfill_in = hfill_ff; ictr_in = ictr_ff;
      cur_in = cur_ff; lch_in = lch_ff; idx_in = idx_ff; cnt_in = cnt_ff;
      lim_in = lim_ff; ent_in = ent_ff; est_in = est_ff;
      h_we = 1'b0; h_wa = idx_ff; h_wd = cur_ff; h_ra = '0;
      r_we = 1'b0; r_wa = tail_sum[RA-1:0]; r_wd = ent_ff; r_ra = head_ff;
      t = ent_ff[dtq_pkg::ENTRY_BITS-1 -: dtq_pkg::TASK_BITS];
      iv = ent_ff[dtq_pkg::IVAL_BITS-1:0];
      fin = 1'b0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            est_in = dtq_pkg::ST_OK;
            ent_in = {req_ff.task_id[dtq_pkg::TASK_BITS-1:0],
                      (req_ff.command == dtq_pkg::CMD_PERIODIC) ? req_ff.delay_ticks
                                                                : 24'd0};
            state_in = S_RESP;
            if (stopped_ff) begin
               est_in = dtq_pkg::ST_IGNORED;
            end else begin
               case (req_ff.command)
                  dtq_pkg::CMD_POST, dtq_pkg::CMD_DELAYED, dtq_pkg::CMD_PERIODIC: begin
                     if (req_ff.command == dtq_pkg::CMD_POST || req_ff.delay_ticks == '0)
                     begin
                        ent_in = {req_ff.task_id[dtq_pkg::TASK_BITS-1:0], 24'd0};
                        if (rfill_ff == (RA+1)'(dtq_pkg::READY_DEPTH)) begin
                           est_in = dtq_pkg::ST_DROPPED;
                        end else begin
                           r_we = 1'b1;
                           r_wd = {req_ff.task_id[dtq_pkg::TASK_BITS-1:0], 24'd0};
                           rfill_in = rfill_ff + 1'b1;
                        end
                     end else if (hfill_ff == (HA+1)'(dtq_pkg::HEAP_DEPTH)) begin
                        est_in = dtq_pkg::ST_DROPPED;
                     end else begin
                        cur_in.due = dtq_pkg::due_after(time_ff, req_ff.delay_ticks);
                        cur_in.order = ictr_ff;
                        cur_in.entry = ent_in;
                        ictr_in = ictr_ff + 1'b1;
                        idx_in = hfill_ff[HA-1:0];
                        hfill_in = hfill_ff + 1'b1;
                        ret_in = S_RESP;
                        state_in = S_HI_UP;
                     end
                  end
                  dtq_pkg::CMD_POLL: begin
                     cnt_in = '0;
                     lim_in = (req_ff.unlimited || req_ff.max_count > 6'd32) ? 6'd32
                                                                         : req_ff.max_count;
                     state_in = S_MV_RD;
                  end
                  dtq_pkg::CMD_TICK: time_in = time_ff + 1'b1;
                  dtq_pkg::CMD_SHUTDOWN: begin
                     stopped_in = 1'b1; head_in = '0; rfill_in = '0; hfill_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         // Sift-up: node cur at idx (not yet written).
         S_HI_UP: begin
            if (idx_ff == '0) begin
               h_we = 1'b1;
               state_in = ret_ff;
            end else begin
               h_ra = pidx[HA-1:0];
               state_in = S_HI_CMP;
            end
         end
         S_HI_CMP: begin
            h_we = 1'b1;
            if (dtq_pkg::node_less(cur_ff, h_rd)) begin
               h_wd = h_rd;
               idx_in = pidx[HA-1:0];
               state_in = S_HI_UP;
            end else begin
               state_in = ret_ff;
            end
         end
         // Move due entries into the FIFO.
         S_MV_RD: begin
            h_ra = '0;
            if (hfill_ff == '0 || rfill_ff == (RA+1)'(dtq_pkg::READY_DEPTH))
               state_in = S_EM_RD;
            else
               state_in = S_MV_CHK;
         end
         S_MV_CHK: begin
            if (h_rd.due <= time_ff) begin
               r_we = 1'b1;
               r_wd = h_rd.entry;
               rfill_in = rfill_ff + 1'b1;
               hfill_in = hfill_ff - 1'b1;
               state_in = S_PL_RD;
            end else begin
               state_in = S_EM_RD;
            end
         end
         S_PL_RD: begin
            h_ra = hfill_ff[HA-1:0];
            idx_in = '0;
            state_in = (hfill_ff == '0) ? S_MV_RD : S_PL_LAST;
         end
         S_PL_LAST: begin
            cur_in = h_rd;
            state_in = S_SD_L;
         end
         // Sift-down of cur from idx.
         S_SD_L: begin
            if (lidx >= hfill_ff) begin
               h_we = 1'b1;
               state_in = S_MV_RD;
            end else begin
               h_ra = lidx[HA-1:0];
               state_in = S_SD_R;
            end
         end
         S_SD_R: begin
            lch_in = h_rd;
            h_ra = ridx[HA-1:0];
            state_in = S_SD_CMP;
         end
         S_SD_CMP: begin
            h_we = 1'b1;
            if (ridx < hfill_ff && dtq_pkg::node_less(h_rd, lch_ff)
                && dtq_pkg::node_less(h_rd, cur_ff)) begin
               h_wd = h_rd;
               idx_in = ridx[HA-1:0];
               state_in = S_SD_L;
            end else if (dtq_pkg::node_less(lch_ff, cur_ff)) begin
               h_wd = lch_ff;
               idx_in = lidx[HA-1:0];
               state_in = S_SD_L;
            end else begin
               state_in = S_MV_RD;
            end
         end
         // Hand out tasks.
         S_EM_RD: begin
            r_ra = head_ff;
            if (rfill_ff == '0 || cnt_ff >= lim_ff) begin
               if (cnt_ff == '0) begin
                  est_in = dtq_pkg::ST_OK;
                  state_in = S_RESP;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               state_in = S_EM_GOT;
            end
         end
         S_EM_GOT: begin
            ent_in = r_rd;
            head_in = head_ff + 1'b1;
            rfill_in = rfill_ff - 1'b1;
            est_in = dtq_pkg::ST_OK;
            state_in = S_EM_OUT;
            if (r_rd[dtq_pkg::IVAL_BITS-1:0] != '0) begin
               if (hfill_ff == (HA+1)'(dtq_pkg::HEAP_DEPTH)) begin
                  est_in = dtq_pkg::ST_DROPPED;
               end else begin
                  cur_in.due = dtq_pkg::due_after(time_ff, r_rd[dtq_pkg::IVAL_BITS-1:0]);
                  cur_in.order = ictr_ff;
                  cur_in.entry = r_rd;
                  ictr_in = ictr_ff + 1'b1;
                  idx_in = hfill_ff[HA-1:0];
                  hfill_in = hfill_ff + 1'b1;
                  ret_in = S_EM_OUT;
                  state_in = S_HI_UP;
               end
            end
         end
         S_EM_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               fin = (rfill_ff == '0) || (cnt_ff + 6'd1 >= lim_ff);
               rsp_valid_in = 1'b1;
               rsp_in.out_task = 16'(t);
               rsp_in.task_valid = 1'b1;
               rsp_in.periodic = (iv != '0);
               rsp_in.last = fin;
               rsp_in.executed_count = fin ? cnt_ff + 6'd1 : 6'd0;
               rsp_in.status = est_ff;
               rsp_in.queues_empty = (rfill_ff == '0) && (hfill_ff == '0);
               cnt_in = cnt_ff + 6'd1;
               state_in = S_EM_RD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in = '0;
               rsp_in.last = 1'b1;
               rsp_in.status = est_ff;
               rsp_in.queues_empty = (rfill_ff == '0) && (hfill_ff == '0);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         time_ff <= '0; stopped_ff <= 1'b0; head_ff <= '0;
         rfill_ff <= '0; hfill_ff <= '0; ictr_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         time_ff <= time_in; stopped_ff <= stopped_in; head_ff <= head_in;
         rfill_ff <= rfill_in; hfill_ff <= hfill_in; ictr_ff <= ictr_in;
      end
      ret_ff <= ret_in; req_ff <= req_in; rsp_ff <= rsp_in;
      cur_ff <= cur_in; lch_ff <= lch_in; idx_ff <= idx_in;
      cnt_ff <= cnt_in; lim_ff <= lim_in; ent_ff <= ent_in; est_ff <= est_in;
   end

   // Check: fills never exceed depth; a stalled beat holds; shutdown empties the stores.
   `DTQ_ASSERT_IMP(a_rfill, clock, reset, 1'b1,
      rfill_ff <= (RA+1)'(dtq_pkg::READY_DEPTH), "ready fill overflow")
   `DTQ_ASSERT_IMP(a_hfill, clock, reset, 1'b1,
      hfill_ff <= (HA+1)'(dtq_pkg::HEAP_DEPTH), "heap fill overflow")
   `DTQ_ASSERT_NEXT(a_rsphold, clock, reset, rsp_valid_ff && !rsp_ready,
      rsp_valid_ff && $stable(rsp_ff), "response beat not held")
   `DTQ_ASSERT_IMP(a_stopempty, clock, reset, stopped_ff,
      rfill_ff == '0 && hfill_ff == '0, "stores not empty after shutdown")
endmodule
